### sv/hmtvn_pkg.sv
// Shared constants, types and width helpers for the heightmap vertex-normal block.
package hmtvn_pkg;

   localparam int SIDE_W         = 9;
   localparam int IDX_W          = 16;
   localparam int PIXEL_W        = 32;
   localparam int HEIGHT_W       = 8;
   localparam int POS_W          = 8;
   localparam int NORMAL_W       = 16;
   localparam int TEX_W          = 17;
   localparam int AREA_W         = 2 * SIDE_W;
   localparam int CSR_IDX_W      = 1;
   localparam int MAX_SIDE_DEF   = 256;
   localparam int FRAC_BITS_DEF  = 14;
   localparam int SIDE_RESET     = 256;
   localparam int SIDE_MIN       = 2;
   localparam int VEC_Y          = 10;   // vertical cross-product term with x,z scaled by ten
   localparam int TEX_SHIFT      = 17;   // 2 * 2^16: doubled for round-half-up
   localparam int NEIGHBORS      = 9;

   localparam logic KIND_LOAD = 1'b0;
   localparam logic KIND_READ = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_GRID_WIDTH = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_DEPTH = 1'd1;

   typedef struct packed {
      logic                en;
      logic [IDX_W-1:0]    addr;
      logic [HEIGHT_W-1:0] data;
   } ram_wr_type;

   // quotient bits of the shared divider
   function automatic int quot_width(input int frac);
      return 2 * frac + 3;
   endfunction

   // squared-length width (divisor width)
   function automatic int len_width(input int frac);
      return 2 * frac + 8;
   endfunction

   // dividend width
   function automatic int dvd_width(input int frac);
      return 4 * frac + 8;
   endfunction

endpackage

### sv/hmtvn_height_ram.sv
// Height store: 64K x 8 memory, one write port and one registered read port.
module hmtvn_height_ram (
   input  logic                            clock,
   input  hmtvn_pkg::ram_wr_type           wr,
   input  logic [hmtvn_pkg::IDX_W-1:0]     rd_addr,
   output logic [hmtvn_pkg::HEIGHT_W-1:0]  rd_data
);

   localparam int DEPTH = 1 << hmtvn_pkg::IDX_W;

   logic [hmtvn_pkg::HEIGHT_W-1:0] mem [DEPTH];
   logic [hmtvn_pkg::HEIGHT_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/hmtvn_divider.sv
// Restoring divider, one quotient bit per cycle.
module hmtvn_divider #(
   parameter int FRAC_BITS = hmtvn_pkg::FRAC_BITS_DEF
) (
   input  logic                                           clock,
   input  logic                                           reset,
   input  logic                                           start,
   input  logic [hmtvn_pkg::dvd_width(FRAC_BITS)-1:0]     dividend,
   input  logic [hmtvn_pkg::len_width(FRAC_BITS)-1:0]     divisor,
   output logic                                           done,
   output logic [hmtvn_pkg::quot_width(FRAC_BITS)-1:0]    quotient,
   output logic [hmtvn_pkg::len_width(FRAC_BITS)-1:0]     remainder
);

   localparam int QW  = hmtvn_pkg::quot_width(FRAC_BITS);
   localparam int LW  = hmtvn_pkg::len_width(FRAC_BITS);
   localparam int CW  = $clog2(QW + 1);

   logic [LW-1:0] rem_ff,  rem_in;
   logic [QW-1:0] work_ff, work_in;
   logic [CW-1:0] cnt_ff,  cnt_in;
   logic          run_ff,  run_in;
   logic          done_ff, done_in;
   logic [LW:0]   shifted;
   logic          ge;

   // caller guarantees dividend < divisor * 2^QW, so the top part starts below divisor
   assign shifted = {rem_ff, work_ff[QW-1]};
   assign ge      = shifted >= {1'b0, divisor};

   always_comb begin
      rem_in  = rem_ff;
      work_in = work_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = LW'(dividend >> QW);
         work_in = dividend[QW-1:0];
         cnt_in  = CW'(QW);
         run_in  = 1'b1;
      end else if (run_ff) begin
         rem_in  = ge ? LW'(shifted - {1'b0, divisor}) : LW'(shifted);
         work_in = {work_ff[QW-2:0], ge};
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      rem_ff  <= rem_in;
      work_ff <= work_in;
   end

   assign done      = done_ff;
   assign quotient  = work_ff;
   assign remainder = rem_ff;

endmodule

### sv/heightmap_terrain_vertex_normals_top.sv
// Heightmap vertex unit: height store, sequencer, shared squarer and divider.
// A load transaction writes its height in the cycle it is accepted and busy stays low.
// A read transaction runs a sequencer over one shared squarer and one bit-serial divider:
// row/column and both texcoords take three divides, nine neighbor heights come from the
// store, then up to six triangle normals (six at an interior vertex, one at a corner
// touching one triangle) and the final sum are each made unit length, one component at
// a time as an exact divide followed by a bit-serial square root of F+2 bits, F being
// the normal fraction bits. A zero vector component skips its divide and root.
// The result is shown for exactly one cycle with rsp_valid and cannot be held off by the
// receiver; busy drops on the following cycle. Reads outside the grid give no result.
// The height store has no reset: reading a vertex before it and its neighbors are loaded
// returns undefined values.
module heightmap_terrain_vertex_normals_top #(
   parameter int MAX_SIDE         = hmtvn_pkg::MAX_SIDE_DEF,
   parameter int NORMAL_FRAC_BITS = hmtvn_pkg::FRAC_BITS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  logic                                   req_kind,
   input  logic [hmtvn_pkg::IDX_W-1:0]            req_vertex_index,
   input  logic [hmtvn_pkg::PIXEL_W-1:0]          req_pixel,
   output logic                                   rsp_valid,
   output logic [hmtvn_pkg::POS_W-1:0]            rsp_pos_x,
   output logic [hmtvn_pkg::POS_W-1:0]            rsp_pos_z,
   output logic [hmtvn_pkg::HEIGHT_W-1:0]         rsp_height_tenths,
   output logic signed [hmtvn_pkg::NORMAL_W-1:0]  rsp_normal_x,
   output logic signed [hmtvn_pkg::NORMAL_W-1:0]  rsp_normal_y,
   output logic signed [hmtvn_pkg::NORMAL_W-1:0]  rsp_normal_z,
   output logic [hmtvn_pkg::TEX_W-1:0]            rsp_tex_u,
   output logic [hmtvn_pkg::TEX_W-1:0]            rsp_tex_v,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [hmtvn_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [hmtvn_pkg::SIDE_W-1:0]           csr_data
);

   localparam int F    = NORMAL_FRAC_BITS;
   localparam int QW   = hmtvn_pkg::quot_width(F);
   localparam int LW   = hmtvn_pkg::len_width(F);
   localparam int DVW  = hmtvn_pkg::dvd_width(F);
   localparam int SW   = F + 2;        // square root width
   localparam int MW   = F + 3;        // magnitude width of a vector component
   localparam int AW   = F + 4;        // signed component width
   localparam int PW   = 2 * MW;
   localparam int SBW  = $clog2(SW);
   localparam int SIW  = hmtvn_pkg::SIDE_W;
   localparam int IW   = hmtvn_pkg::IDX_W;
   localparam int HW   = hmtvn_pkg::HEIGHT_W;
   localparam int NW   = hmtvn_pkg::NORMAL_W;
   localparam int TW   = hmtvn_pkg::TEX_W;
   localparam int FKW  = $clog2(hmtvn_pkg::NEIGHBORS + 1);

   typedef enum logic [11:0] {
      ST_IDLE   = 12'b0000_0000_0001,
      ST_ROWCOL = 12'b0000_0000_0010,
      ST_TEXU   = 12'b0000_0000_0100,
      ST_TEXV   = 12'b0000_0000_1000,
      ST_FETCH  = 12'b0000_0001_0000,
      ST_TRI    = 12'b0000_0010_0000,
      ST_LEN    = 12'b0000_0100_0000,
      ST_CSQ    = 12'b0000_1000_0000,
      ST_CDIV   = 12'b0001_0000_0000,
      ST_CSQRT  = 12'b0010_0000_0000,
      ST_CACC   = 12'b0100_0000_0000,
      ST_DONE   = 12'b1000_0000_0000
   } state_type;

   state_type state_ff, state_in;

   logic [SIW-1:0] grid_w_ff, grid_w_in, grid_d_ff, grid_d_in;
   logic [IW-1:0]  idx_ff, idx_in;
   logic [SIW-1:0] row_ff, row_in, col_ff, col_in;
   logic [TW-1:0]  tex_u_ff, tex_u_in, tex_v_ff, tex_v_in;
   logic [FKW-1:0] fk_ff, fk_in;
   logic [HW-1:0]  h_ff [hmtvn_pkg::NEIGHBORS];
   logic [2:0]     tri_ff, tri_in;
   logic [1:0]     comp_ff, comp_in;
   logic           final_ff, final_in;
   logic signed [AW-1:0] vec_x_ff, vec_x_in, vec_y_ff, vec_y_in, vec_z_ff, vec_z_in;
   logic signed [AW-1:0] acc_x_ff, acc_x_in, acc_y_ff, acc_y_in, acc_z_ff, acc_z_in;
   logic signed [AW-1:0] nrm_x_ff, nrm_x_in, nrm_y_ff, nrm_y_in, nrm_z_ff, nrm_z_in;
   logic [LW-1:0]  len_ff, len_in;
   logic [QW-1:0]  q_ff, q_in;
   logic [SW-1:0]  s_ff, s_in;
   logic [SBW-1:0] sb_ff, sb_in;
   logic           div_go_ff, div_go_in;
   logic [DVW-1:0] div_dvd_ff, div_dvd_in;
   logic [LW-1:0]  div_dvs_ff, div_dvs_in;

   logic           div_done;
   logic [QW-1:0]  div_quot;
   logic [LW-1:0]  div_rem;

   hmtvn_pkg::ram_wr_type ram_wr;
   logic [IW-1:0]  rd_addr;
   logic [HW-1:0]  rd_data;

   logic                 accept, in_range;
   logic [hmtvn_pkg::AREA_W-1:0] area;
   logic signed [AW-1:0] sel_v;
   logic [MW-1:0]        mag, mul_a;
   logic [PW-1:0]        prod;
   logic [SW-1:0]        cand;
   logic [SW-1:0]        m;
   logic signed [AW-1:0] cval;
   logic                 qv00, qv01, qv10, qv11, tri_ok;
   logic signed [AW-1:0] t_x, t_z;
   logic [IW-1:0]        wv;

   function automatic logic [SIW-1:0] clamp_side(input logic [SIW-1:0] v);
      if (32'(v) < hmtvn_pkg::SIDE_MIN) begin
         return SIW'(hmtvn_pkg::SIDE_MIN);
      end else if (32'(v) > MAX_SIDE) begin
         return SIW'(MAX_SIDE);
      end
      return v;
   endfunction

   function automatic logic signed [AW-1:0] hdiff(input logic [HW-1:0] a,
                                                  input logic [HW-1:0] b);
      return AW'($signed({1'b0, a})) - AW'($signed({1'b0, b}));
   endfunction

   // quad (di,dj) lies inside the grid
   function automatic logic quad_ok(input logic [SIW-1:0] r, input logic [SIW-1:0] c,
                                    input logic di, input logic dj,
                                    input logic [SIW-1:0] w, input logic [SIW-1:0] d);
      logic [SIW:0] rr;
      logic [SIW:0] cc;
      rr = {1'b0, r} + (SIW+1)'(di);
      cc = {1'b0, c} + (SIW+1)'(dj);
      return (rr != '0) && (cc != '0) &&
             (rr <= {1'b0, d} - 1'b1) && (cc <= {1'b0, w} - 1'b1);
   endfunction

   hmtvn_height_ram u_ram (
      .clock   (clock),
      .wr      (ram_wr),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   hmtvn_divider #(.FRAC_BITS(F)) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_go_ff),
      .dividend  (div_dvd_ff),
      .divisor   (div_dvs_ff),
      .done      (div_done),
      .quotient  (div_quot),
      .remainder (div_rem)
   );

   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start && !busy;
   assign area      = grid_w_ff * grid_d_ff;
   assign in_range  = {2'b0, req_vertex_index} < area;
   assign csr_ready = 1'b1;

   assign ram_wr.en   = accept && in_range && (req_kind == hmtvn_pkg::KIND_LOAD);
   assign ram_wr.addr = req_vertex_index;
   assign ram_wr.data = req_pixel[HW-1:0];

   // neighbor address in the 3x3 window, wrapping like the store index
   assign wv = IW'(grid_w_ff);
   always_comb begin
      case (fk_ff)
         4'd0:    rd_addr = idx_ff - wv - 1'b1;
         4'd1:    rd_addr = idx_ff - wv;
         4'd2:    rd_addr = idx_ff - wv + 1'b1;
         4'd3:    rd_addr = idx_ff - 1'b1;
         4'd4:    rd_addr = idx_ff;
         4'd5:    rd_addr = idx_ff + 1'b1;
         4'd6:    rd_addr = idx_ff + wv - 1'b1;
         4'd7:    rd_addr = idx_ff + wv;
         4'd8:    rd_addr = idx_ff + wv + 1'b1;
         default: rd_addr = idx_ff;
      endcase
   end

   assign qv00 = quad_ok(row_ff, col_ff, 1'b0, 1'b0, grid_w_ff, grid_d_ff);
   assign qv01 = quad_ok(row_ff, col_ff, 1'b0, 1'b1, grid_w_ff, grid_d_ff);
   assign qv10 = quad_ok(row_ff, col_ff, 1'b1, 1'b0, grid_w_ff, grid_d_ff);
   assign qv11 = quad_ok(row_ff, col_ff, 1'b1, 1'b1, grid_w_ff, grid_d_ff);

   // triangles touching the center vertex; window index 4 is the vertex itself
   always_comb begin
      case (tri_ff)
         3'd0: begin
            tri_ok = qv00; t_x = hdiff(h_ff[3], h_ff[4]); t_z = hdiff(h_ff[1], h_ff[4]);
         end
         3'd1: begin
            tri_ok = qv01; t_x = hdiff(h_ff[4], h_ff[5]); t_z = hdiff(h_ff[2], h_ff[5]);
         end
         3'd2: begin
            tri_ok = qv01; t_x = hdiff(h_ff[1], h_ff[2]); t_z = hdiff(h_ff[1], h_ff[4]);
         end
         3'd3: begin
            tri_ok = qv10; t_x = hdiff(h_ff[6], h_ff[7]); t_z = hdiff(h_ff[4], h_ff[7]);
         end
         3'd4: begin
            tri_ok = qv10; t_x = hdiff(h_ff[3], h_ff[4]); t_z = hdiff(h_ff[3], h_ff[6]);
         end
         3'd5: begin
            tri_ok = qv11; t_x = hdiff(h_ff[4], h_ff[5]); t_z = hdiff(h_ff[4], h_ff[7]);
         end
         default: begin
            tri_ok = 1'b0; t_x = '0; t_z = '0;
         end
      endcase
   end

   always_comb begin
      case (comp_ff)
         2'd0:    sel_v = vec_x_ff;
         2'd1:    sel_v = vec_y_ff;
         default: sel_v = vec_z_ff;
      endcase
   end

   assign mag   = sel_v[AW-1] ? MW'(-sel_v) : MW'(sel_v);
   assign cand  = s_ff | (SW'(1) << sb_ff);
   assign mul_a = (state_ff == ST_CSQRT) ? MW'(cand) : mag;
   assign prod  = mul_a * mul_a;
   // round half up: s is floor(sqrt(q)) at twice the scale, so (s+1)/2 rounds it
   assign m     = SW'(({1'b0, s_ff} + 1'b1) >> 1);
   assign cval  = sel_v[AW-1] ? -AW'(m) : AW'(m);

   always_comb begin
      state_in   = state_ff;
      grid_w_in  = grid_w_ff;
      grid_d_in  = grid_d_ff;
      idx_in     = idx_ff;
      row_in     = row_ff;
      col_in     = col_ff;
      tex_u_in   = tex_u_ff;
      tex_v_in   = tex_v_ff;
      fk_in      = fk_ff;
      tri_in     = tri_ff;
      comp_in    = comp_ff;
      final_in   = final_ff;
      vec_x_in   = vec_x_ff;
      vec_y_in   = vec_y_ff;
      vec_z_in   = vec_z_ff;
      acc_x_in   = acc_x_ff;
      acc_y_in   = acc_y_ff;
      acc_z_in   = acc_z_ff;
      nrm_x_in   = nrm_x_ff;
      nrm_y_in   = nrm_y_ff;
      nrm_z_in   = nrm_z_ff;
      len_in     = len_ff;
      q_in       = q_ff;
      s_in       = s_ff;
      sb_in      = sb_ff;
      div_go_in  = 1'b0;
      div_dvd_in = div_dvd_ff;
      div_dvs_in = div_dvs_ff;

      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            hmtvn_pkg::CSR_GRID_WIDTH: grid_w_in = clamp_side(csr_data);
            hmtvn_pkg::CSR_GRID_DEPTH: grid_d_in = clamp_side(csr_data);
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept && in_range && (req_kind == hmtvn_pkg::KIND_READ)) begin
               idx_in     = req_vertex_index;
               div_go_in  = 1'b1;
               div_dvd_in = DVW'(req_vertex_index);
               div_dvs_in = LW'(grid_w_ff);
               state_in   = ST_ROWCOL;
            end
         end
         ST_ROWCOL: begin
            if (div_done) begin
               row_in     = SIW'(div_quot);
               col_in     = SIW'(div_rem);
               div_go_in  = 1'b1;
               div_dvd_in = (DVW'(div_rem[SIW-1:0]) << hmtvn_pkg::TEX_SHIFT) +
                            DVW'(grid_w_ff - 1'b1);
               div_dvs_in = LW'(grid_w_ff - 1'b1) << 1;
               state_in   = ST_TEXU;
            end
         end
         ST_TEXU: begin
            if (div_done) begin
               tex_u_in   = TW'(div_quot);
               div_go_in  = 1'b1;
               div_dvd_in = (DVW'(row_ff) << hmtvn_pkg::TEX_SHIFT) +
                            DVW'(grid_d_ff - 1'b1);
               div_dvs_in = LW'(grid_d_ff - 1'b1) << 1;
               state_in   = ST_TEXV;
            end
         end
         ST_TEXV: begin
            if (div_done) begin
               tex_v_in = TW'(div_quot);
               fk_in    = '0;
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            fk_in = fk_ff + 1'b1;
            if (fk_ff == FKW'(hmtvn_pkg::NEIGHBORS)) begin
               tri_in   = '0;
               final_in = 1'b0;
               acc_x_in = '0;
               acc_y_in = '0;
               acc_z_in = '0;
               state_in = ST_TRI;
            end
         end
         ST_TRI: begin
            comp_in = '0;
            len_in  = '0;
            if (tri_ff == 3'd6) begin
               final_in = 1'b1;
               vec_x_in = acc_x_ff;
               vec_y_in = acc_y_ff;
               vec_z_in = acc_z_ff;
               state_in = ST_LEN;
            end else if (tri_ok) begin
               vec_x_in = t_x;
               vec_y_in = AW'(hmtvn_pkg::VEC_Y);
               vec_z_in = t_z;
               state_in = ST_LEN;
            end else begin
               tri_in = tri_ff + 1'b1;
            end
         end
         ST_LEN: begin
            len_in = len_ff + LW'(prod);
            if (comp_ff == 2'd2) begin
               comp_in  = '0;
               state_in = ST_CSQ;
            end else begin
               comp_in = comp_ff + 1'b1;
            end
         end
         ST_CSQ: begin
            if (mag == '0) begin
               s_in     = '0;
               state_in = ST_CACC;
            end else begin
               div_go_in  = 1'b1;
               div_dvd_in = DVW'(prod) << (2 * F + 2);
               div_dvs_in = len_ff;
               state_in   = ST_CDIV;
            end
         end
         ST_CDIV: begin
            if (div_done) begin
               q_in     = div_quot;
               s_in     = '0;
               sb_in    = SBW'(SW - 1);
               state_in = ST_CSQRT;
            end
         end
         ST_CSQRT: begin
            if (prod <= PW'(q_ff)) begin
               s_in = cand;
            end
            if (sb_ff == '0) begin
               state_in = ST_CACC;
            end else begin
               sb_in = sb_ff - 1'b1;
            end
         end
         ST_CACC: begin
            if (final_ff) begin
               case (comp_ff)
                  2'd0:    nrm_x_in = cval;
                  2'd1:    nrm_y_in = cval;
                  default: nrm_z_in = cval;
               endcase
            end else begin
               case (comp_ff)
                  2'd0:    acc_x_in = acc_x_ff + cval;
                  2'd1:    acc_y_in = acc_y_ff + cval;
                  default: acc_z_in = acc_z_ff + cval;
               endcase
            end
            if (comp_ff == 2'd2) begin
               if (final_ff) begin
                  state_in = ST_DONE;
               end else begin
                  tri_in   = tri_ff + 1'b1;
                  state_in = ST_TRI;
               end
            end else begin
               comp_in  = comp_ff + 1'b1;
               state_in = ST_CSQ;
            end
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         grid_w_ff <= SIW'(hmtvn_pkg::SIDE_RESET);
         grid_d_ff <= SIW'(hmtvn_pkg::SIDE_RESET);
         div_go_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         grid_w_ff <= grid_w_in;
         grid_d_ff <= grid_d_in;
         div_go_ff <= div_go_in;
      end
      idx_ff     <= idx_in;
      row_ff     <= row_in;
      col_ff     <= col_in;
      tex_u_ff   <= tex_u_in;
      tex_v_ff   <= tex_v_in;
      fk_ff      <= fk_in;
      tri_ff     <= tri_in;
      comp_ff    <= comp_in;
      final_ff   <= final_in;
      vec_x_ff   <= vec_x_in;
      vec_y_ff   <= vec_y_in;
      vec_z_ff   <= vec_z_in;
      acc_x_ff   <= acc_x_in;
      acc_y_ff   <= acc_y_in;
      acc_z_ff   <= acc_z_in;
      nrm_x_ff   <= nrm_x_in;
      nrm_y_ff   <= nrm_y_in;
      nrm_z_ff   <= nrm_z_in;
      len_ff     <= len_in;
      q_ff       <= q_in;
      s_ff       <= s_in;
      sb_ff      <= sb_in;
      div_dvd_ff <= div_dvd_in;
      div_dvs_ff <= div_dvs_in;
      // read data arrives in the cycle after its address is issued
      if ((state_ff == ST_FETCH) && (fk_ff != '0)) begin
         h_ff[fk_ff - 1'b1] <= rd_data;
      end
   end

   assign rsp_valid         = (state_ff == ST_DONE);
   assign rsp_pos_x         = col_ff[hmtvn_pkg::POS_W-1:0];
   assign rsp_pos_z         = row_ff[hmtvn_pkg::POS_W-1:0];
   assign rsp_height_tenths = h_ff[4];
   assign rsp_normal_x      = NW'(nrm_x_ff);
   assign rsp_normal_y      = NW'(nrm_y_ff);
   assign rsp_normal_z      = NW'(nrm_z_ff);
   assign rsp_tex_u         = tex_u_ff;
   assign rsp_tex_v         = tex_v_ff;

endmodule

### sv/hmtvn_checker.sv
// Port-level checks for the heightmap vertex unit, bound to the top level.
module hmtvn_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           start,
   input logic                           busy,
   input logic                           req_kind,
   input logic                           rsp_valid,
   input logic [hmtvn_pkg::TEX_W-1:0]    rsp_tex_u,
   input logic [hmtvn_pkg::TEX_W-1:0]    rsp_tex_v
);

   // a result only appears while a read transaction is in flight
   a_rsp_while_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result strobe without busy");

   // one strobe per read
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held longer than one cycle");

   // loads finish in the accepting cycle and never produce a result
   a_load_quiet: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_kind == hmtvn_pkg::KIND_LOAD)) |=> (!busy && !rsp_valid))
      else $error("load transaction left the unit busy or produced a result");

   a_read_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_kind == hmtvn_pkg::KIND_READ)) |=> !rsp_valid)
      else $error("read result too early");

   a_tex_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_tex_u <= 17'h10000) && (rsp_tex_v <= 17'h10000)))
      else $error("texture coordinate above one");

endmodule

bind heightmap_terrain_vertex_normals_top hmtvn_checker u_hmtvn_checker (.*);
